// ===== rtl/core/spcp_pkg.sv =====
// shared types and constants for the segment pair closest point block
// no dependencies; every file in rtl/core imports this package
`timescale 1ns / 1ps

package spcp_pkg;

	// coordinate, direction and dot product widths
	localparam int CW = 32;
	localparam int DW = CW + 1;
	localparam int MW = 2 * DW;
	localparam int SW = MW + 2;
	localparam int QB = 16;
	localparam int PW = SW - QB;
	localparam int LW = PW / 2;
	localparam int WW = 2 * PW;
	localparam int TW = PW + QB + 3;
	localparam int XW = DW + QB + 2;
	localparam int RW = CW + 4;

	// divider pipeline length: one setup stage and one stage per quotient bit
	localparam int RATIO_LAT = QB + 1;

	// queue between front and back
	localparam int QDEPTH = 8;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = QAW + 1;

	// register file
	localparam int THR_W = 16;
	localparam int PAW = 3;
	localparam logic [THR_W-1:0] THR_RESET = 16'd1;
	localparam logic REG_THR = 1'b0;

	localparam logic [QB:0] Q_ONE = 17'h10000;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] dir_t;
	typedef logic signed [PW-1:0] dot_t;

	typedef enum logic [1:0] {
		KIND_BOTH_PT,
		KIND_FIRST_PT,
		KIND_SECOND_PT,
		KIND_GENERAL
	} kind_t;

	typedef enum logic [1:0] {
		DST_NONE,
		DST_S1,
		DST_S2
	} dst_t;

	typedef struct packed {
		coord_t [2:0] p0;
		coord_t [2:0] p1;
		coord_t [2:0] q0;
		coord_t [2:0] q1;
	} seg_t;

	typedef struct packed {
		coord_t [2:0] p0;
		coord_t [2:0] q0;
		dir_t [2:0] d1;
		dir_t [2:0] d2;
		dot_t a;
		dot_t b;
		dot_t c;
		dot_t e;
		dot_t f;
		kind_t kind;
	} item_t;

	typedef struct packed {
		logic [QB:0] s1;
		logic [QB:0] s2;
		coord_t [2:0] n1;
		coord_t [2:0] n2;
	} res_t;

endpackage

// ===== rtl/core/spcp_front.sv =====
// front end: captures a segment pair, forms directions and dot products, classifies
// depends on spcp_pkg
`timescale 1ns / 1ps

module spcp_front (
	input logic clk,
	input logic arst_n,
	input logic take,
	input spcp_pkg::seg_t seg,
	input logic [spcp_pkg::THR_W-1:0] thr,
	output logic push,
	output spcp_pkg::item_t item
);
	import spcp_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	seg_t seg_s1;
	coord_t [2:0] p0_s2, q0_s2, p0_s3, q0_s3;
	dir_t [2:0] d1_s2, d2_s2, r_s2, d1_s3, d2_s3;
	logic signed [MW-1:0] m_aa_s3 [3];
	logic signed [MW-1:0] m_ee_s3 [3];
	logic signed [MW-1:0] m_bb_s3 [3];
	logic signed [MW-1:0] m_cc_s3 [3];
	logic signed [MW-1:0] m_ff_s3 [3];
	dot_t a_c, b_c, c_c, e_c, f_c;
	logic a_pt, e_pt;
	kind_t kind_c;
	item_t item_s4;

	// sum of three exact products, rescaled to q16.16 with floor
	function automatic dot_t dot3(input logic signed [MW-1:0] m0,
			input logic signed [MW-1:0] m1, input logic signed [MW-1:0] m2);
		logic signed [SW-1:0] s;
		s = SW'(m0) + SW'(m1) + SW'(m2);
		return dot_t'(s[SW-1:QB]);
	endfunction

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// capture the transaction
	always_ff @(posedge clk) begin
		if (take) begin
			seg_s1 <= seg;
		end
	end

	// directions and offset between starts
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d1_s2[i] <= DW'($signed(seg_s1.p1[i])) - DW'($signed(seg_s1.p0[i]));
			d2_s2[i] <= DW'($signed(seg_s1.q1[i])) - DW'($signed(seg_s1.q0[i]));
			r_s2[i] <= DW'($signed(seg_s1.p0[i])) - DW'($signed(seg_s1.q0[i]));
		end
		p0_s2 <= seg_s1.p0;
		q0_s2 <= seg_s1.q0;
	end

	// per axis products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			m_aa_s3[i] <= $signed(d1_s2[i]) * $signed(d1_s2[i]);
			m_ee_s3[i] <= $signed(d2_s2[i]) * $signed(d2_s2[i]);
			m_bb_s3[i] <= $signed(d1_s2[i]) * $signed(d2_s2[i]);
			m_cc_s3[i] <= $signed(d1_s2[i]) * $signed(r_s2[i]);
			m_ff_s3[i] <= $signed(d2_s2[i]) * $signed(r_s2[i]);
		end
		p0_s3 <= p0_s2;
		q0_s3 <= q0_s2;
		d1_s3 <= d1_s2;
		d2_s3 <= d2_s2;
	end

	// dot products and degenerate classification
	always_comb begin
		a_c = dot3(m_aa_s3[0], m_aa_s3[1], m_aa_s3[2]);
		e_c = dot3(m_ee_s3[0], m_ee_s3[1], m_ee_s3[2]);
		b_c = dot3(m_bb_s3[0], m_bb_s3[1], m_bb_s3[2]);
		c_c = dot3(m_cc_s3[0], m_cc_s3[1], m_cc_s3[2]);
		f_c = dot3(m_ff_s3[0], m_ff_s3[1], m_ff_s3[2]);
		a_pt = a_c <= $signed({1'b0, thr});
		e_pt = e_c <= $signed({1'b0, thr});
		priority if (a_pt && e_pt) begin
			kind_c = KIND_BOTH_PT;
		end else if (a_pt) begin
			kind_c = KIND_FIRST_PT;
		end else if (e_pt) begin
			kind_c = KIND_SECOND_PT;
		end else begin
			kind_c = KIND_GENERAL;
		end
	end

	always_ff @(posedge clk) begin
		item_s4.p0 <= p0_s3;
		item_s4.q0 <= q0_s3;
		item_s4.d1 <= d1_s3;
		item_s4.d2 <= d2_s3;
		item_s4.a <= a_c;
		item_s4.b <= b_c;
		item_s4.c <= c_c;
		item_s4.e <= e_c;
		item_s4.f <= f_c;
		item_s4.kind <= kind_c;
	end

	assign push = v_s4;
	assign item = item_s4;

endmodule

// ===== rtl/core/spcp_queue.sv =====
// short queue between front and back, with slot reservation at accept time
// depends on spcp_pkg
`timescale 1ns / 1ps

module spcp_queue (
	input logic clk,
	input logic arst_n,
	input logic take,
	output logic full,
	input logic push,
	input spcp_pkg::item_t wr_item,
	output logic rd_valid,
	output spcp_pkg::item_t rd_item
);
	import spcp_pkg::*;

	item_t mem [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] cnt_q, occ_q;
	logic pop;
	logic rd_valid_q;
	item_t rd_item_q;

	// the back end drains one entry every cycle while the queue holds one
	assign pop = cnt_q != '0;
	assign full = occ_q == QCW'(QDEPTH);

	// pointers, fill count and reservations (front stages plus stored entries)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
			occ_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCW'(push) - QCW'(pop);
			occ_q <= occ_q + QCW'(take) - QCW'(pop);
			rd_valid_q <= pop;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_item_q <= mem[rd_ptr_q];
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_item = rd_item_q;

endmodule

// ===== rtl/core/spcp_ratio.sv =====
// pipelined clamped ratio: min(max(num/den, 0), 1) in q1.16, one quotient bit per stage
// depends on spcp_pkg
`timescale 1ns / 1ps

module spcp_ratio (
	input logic clk,
	input logic signed [spcp_pkg::WW-1:0] num,
	input logic signed [spcp_pkg::WW-1:0] den,
	output logic [spcp_pkg::QB:0] quo
);
	import spcp_pkg::*;

	logic [WW-1:0] rem_s [QB+1];
	logic [WW-1:0] den_s [QB+1];
	logic [QB-1:0] q_s [QB+1];
	logic zero_s [QB+1];
	logic one_s [QB+1];
	logic [WW-1:0] shl [QB+1];
	logic ge [QB+1];

	// shifted remainder and compare for each step
	always_comb begin
		shl[0] = '0;
		ge[0] = 1'b0;
		for (int k = 1; k <= QB; k++) begin
			shl[k] = {rem_s[k-1][WW-2:0], 1'b0};
			ge[k] = shl[k] >= den_s[k-1];
		end
	end

	// setup stage: clamp tests, then restoring division stages
	always_ff @(posedge clk) begin
		zero_s[0] <= num <= $signed(WW'(0));
		one_s[0] <= num >= den;
		rem_s[0] <= num;
		den_s[0] <= den;
		q_s[0] <= '0;
		for (int k = 1; k <= QB; k++) begin
			rem_s[k] <= ge[k] ? shl[k] - den_s[k-1] : shl[k];
			den_s[k] <= den_s[k-1];
			q_s[k] <= {q_s[k-1][QB-2:0], ge[k]};
			zero_s[k] <= zero_s[k-1];
			one_s[k] <= one_s[k-1];
		end
	end

	assign quo = zero_s[QB] ? '0 : (one_s[QB] ? Q_ONE : {1'b0, q_s[QB]});

endmodule

// ===== rtl/core/spcp_solve.sv =====
// back end: denominator and numerator, first ratio, re-clamp, second ratio, points
// depends on spcp_pkg and spcp_ratio
`timescale 1ns / 1ps

module spcp_solve (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input spcp_pkg::item_t in_item,
	input logic [spcp_pkg::THR_W-1:0] thr,
	output logic done,
	output spcp_pkg::res_t res
);
	import spcp_pkg::*;

	typedef struct packed {
		coord_t [2:0] p0;
		coord_t [2:0] q0;
		dir_t [2:0] d1;
		dir_t [2:0] d2;
		dot_t a;
		dot_t b;
		dot_t c;
		dot_t e;
		dot_t f;
		kind_t kind;
		logic par;
	} ctx1_t;

	typedef struct packed {
		coord_t [2:0] p0;
		coord_t [2:0] q0;
		dir_t [2:0] d1;
		dir_t [2:0] d2;
		logic [QB:0] s1;
		logic [QB:0] s2;
		dst_t dst;
	} ctx2_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_d1 [RATIO_LAT];
	logic v_d2 [RATIO_LAT];
	item_t item_s1, item_s2, item_s3;
	dot_t opx [4];
	dot_t opy [4];
	logic [PW-1:0] mx [4];
	logic [PW-1:0] my [4];
	logic [2*LW-1:0] pp_s1 [4][2][2];
	logic neg_s1 [4];
	logic [WW-1:0] full_c [4];
	logic signed [WW-1:0] prod_s2 [4];
	logic signed [WW-1:0] den_s3, num_s3;
	logic par_c;
	ctx1_t dl1_s [RATIO_LAT];
	logic [QB:0] q1, q2;
	ctx1_t c1;
	logic [QB:0] s1g;
	logic signed [TW-1:0] prod_s4;
	logic [QB:0] s1g_s4;
	ctx1_t c1_s4;
	logic signed [TW-1:0] t_c, top_c;
	logic signed [WW-1:0] num2_c, den2_c;
	ctx2_t ctx2_c;
	logic signed [WW-1:0] num2_s5, den2_s5;
	ctx2_t ctx2_s5;
	ctx2_t dl2_s [RATIO_LAT];
	ctx2_t c2;
	logic [QB:0] s1_c, s2_c;
	logic signed [XW-1:0] m1_s6 [3];
	logic signed [XW-1:0] m2_s6 [3];
	coord_t [2:0] p0_s6, q0_s6;
	logic [QB:0] s1_s6, s2_s6;
	res_t res_s7;

	function automatic logic [PW-1:0] mag(input dot_t v);
		return v[PW-1] ? PW'(-v) : PW'(v);
	endfunction

	// start plus floored offset, saturated to 32 bits
	function automatic coord_t place(input coord_t start, input logic signed [XW-1:0] m);
		logic signed [RW-1:0] s;
		s = RW'(start) + RW'(m >>> QB);
		if (s[RW-1:CW-1] == '0 || s[RW-1:CW-1] == '1) begin
			return coord_t'(s[CW-1:0]);
		end
		return s[RW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
	endfunction

	// valid chain through both dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int k = 0; k < RATIO_LAT; k++) begin
				v_d1[k] <= 1'b0;
				v_d2[k] <= 1'b0;
			end
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_d1[0] <= v_s3;
			v_d2[0] <= v_s5;
			for (int k = 1; k < RATIO_LAT; k++) begin
				v_d1[k] <= v_d1[k-1];
				v_d2[k] <= v_d2[k-1];
			end
			v_s4 <= v_d1[RATIO_LAT-1];
			v_s5 <= v_s4;
			v_s6 <= v_d2[RATIO_LAT-1];
			v_s7 <= v_s6;
		end
	end

	// operands: a*e, b*b, b*f, c*e
	always_comb begin
		opx[0] = in_item.a;
		opy[0] = in_item.e;
		opx[1] = in_item.b;
		opy[1] = in_item.b;
		opx[2] = in_item.b;
		opy[2] = in_item.f;
		opx[3] = in_item.c;
		opy[3] = in_item.e;
		for (int k = 0; k < 4; k++) begin
			mx[k] = mag(opx[k]);
			my[k] = mag(opy[k]);
		end
	end

	// limb partial products
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < 2; j++) begin
					pp_s1[k][i][j] <= mx[k][LW*i +: LW] * my[k][LW*j +: LW];
				end
			end
			neg_s1[k] <= opx[k][PW-1] ^ opy[k][PW-1];
		end
		item_s1 <= in_item;
	end

	// recombine limbs and restore sign
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			full_c[k] = WW'(pp_s1[k][0][0])
				+ ((WW'(pp_s1[k][0][1]) + WW'(pp_s1[k][1][0])) << LW)
				+ (WW'(pp_s1[k][1][1]) << (2 * LW));
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			prod_s2[k] <= neg_s1[k] ? -$signed(full_c[k]) : $signed(full_c[k]);
		end
		item_s2 <= item_s1;
	end

	// denominator and first numerator
	always_ff @(posedge clk) begin
		den_s3 <= prod_s2[0] - prod_s2[1];
		num_s3 <= prod_s2[2] - prod_s2[3];
		item_s3 <= item_s2;
	end

	// parallel test on the rescaled denominator
	assign par_c = !((den_s3 >>> QB) > $signed({{(WW-THR_W){1'b0}}, thr}));

	spcp_ratio u_div1 (
		.clk(clk),
		.num(num_s3),
		.den(den_s3),
		.quo(q1)
	);

	// context alongside the first divider
	always_ff @(posedge clk) begin
		dl1_s[0].p0 <= item_s3.p0;
		dl1_s[0].q0 <= item_s3.q0;
		dl1_s[0].d1 <= item_s3.d1;
		dl1_s[0].d2 <= item_s3.d2;
		dl1_s[0].a <= item_s3.a;
		dl1_s[0].b <= item_s3.b;
		dl1_s[0].c <= item_s3.c;
		dl1_s[0].e <= item_s3.e;
		dl1_s[0].f <= item_s3.f;
		dl1_s[0].kind <= item_s3.kind;
		dl1_s[0].par <= par_c;
		for (int k = 1; k < RATIO_LAT; k++) begin
			dl1_s[k] <= dl1_s[k-1];
		end
	end

	// b * s1 for the re-clamp
	assign c1 = dl1_s[RATIO_LAT-1];
	assign s1g = (c1.kind == KIND_GENERAL && !c1.par) ? q1 : '0;

	always_ff @(posedge clk) begin
		prod_s4 <= $signed(c1.b) * $signed({1'b0, s1g});
		s1g_s4 <= s1g;
		c1_s4 <= c1;
	end

	// pick the second ratio and the fixed parameter
	always_comb begin
		t_c = prod_s4 + (TW'($signed(c1_s4.f)) <<< QB);
		top_c = TW'($signed(c1_s4.e)) <<< QB;
		ctx2_c.p0 = c1_s4.p0;
		ctx2_c.q0 = c1_s4.q0;
		ctx2_c.d1 = c1_s4.d1;
		ctx2_c.d2 = c1_s4.d2;
		num2_c = '0;
		den2_c = WW'(1);
		ctx2_c.s1 = '0;
		ctx2_c.s2 = '0;
		ctx2_c.dst = DST_NONE;
		unique case (c1_s4.kind)
			KIND_BOTH_PT: begin
				ctx2_c.dst = DST_NONE;
			end
			KIND_FIRST_PT: begin
				num2_c = WW'($signed(c1_s4.f));
				den2_c = WW'($signed(c1_s4.e));
				ctx2_c.dst = DST_S2;
			end
			KIND_SECOND_PT: begin
				num2_c = -WW'($signed(c1_s4.c));
				den2_c = WW'($signed(c1_s4.a));
				ctx2_c.dst = DST_S1;
			end
			KIND_GENERAL: begin
				priority if (t_c < $signed(TW'(0))) begin
					num2_c = -WW'($signed(c1_s4.c));
					den2_c = WW'($signed(c1_s4.a));
					ctx2_c.dst = DST_S1;
				end else if (t_c > top_c) begin
					num2_c = WW'($signed(c1_s4.b)) - WW'($signed(c1_s4.c));
					den2_c = WW'($signed(c1_s4.a));
					ctx2_c.s2 = Q_ONE;
					ctx2_c.dst = DST_S1;
				end else begin
					num2_c = WW'(t_c);
					den2_c = WW'(top_c);
					ctx2_c.s1 = s1g_s4;
					ctx2_c.dst = DST_S2;
				end
			end
			default: begin
				ctx2_c.dst = DST_NONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		num2_s5 <= num2_c;
		den2_s5 <= den2_c;
		ctx2_s5 <= ctx2_c;
	end

	spcp_ratio u_div2 (
		.clk(clk),
		.num(num2_s5),
		.den(den2_s5),
		.quo(q2)
	);

	// context alongside the second divider
	always_ff @(posedge clk) begin
		dl2_s[0] <= ctx2_s5;
		for (int k = 1; k < RATIO_LAT; k++) begin
			dl2_s[k] <= dl2_s[k-1];
		end
	end

	// final parameters
	assign c2 = dl2_s[RATIO_LAT-1];

	always_comb begin
		s1_c = c2.s1;
		s2_c = c2.s2;
		unique case (c2.dst)
			DST_S1: s1_c = q2;
			DST_S2: s2_c = q2;
			default: begin
				s1_c = c2.s1;
			end
		endcase
	end

	// direction times parameter
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			m1_s6[i] <= $signed(c2.d1[i]) * $signed({1'b0, s1_c});
			m2_s6[i] <= $signed(c2.d2[i]) * $signed({1'b0, s2_c});
		end
		p0_s6 <= c2.p0;
		q0_s6 <= c2.q0;
		s1_s6 <= s1_c;
		s2_s6 <= s2_c;
	end

	// output register
	always_ff @(posedge clk) begin
		res_s7.s1 <= s1_s6;
		res_s7.s2 <= s2_s6;
		for (int i = 0; i < 3; i++) begin
			res_s7.n1[i] <= place(p0_s6[i], m1_s6[i]);
			res_s7.n2[i] <= place(q0_s6[i], m2_s6[i]);
		end
	end

	assign done = v_s7;
	assign res = res_s7;

endmodule

// ===== rtl/core/segment_pair_closest_points.sv =====
// closest points between two 3d segments, q16.16 in, q1.16 parameters and q16.16 points out
// throughput: one pair per cycle; busy rises only when the front queue is out of slots
// rate is set by the two 17-stage ratio pipelines, each taking one new operand pair a cycle
// reset: arst_n clears all valid bits and queue pointers; threshold returns to 1
// results cannot be stalled; done marks each result for a single cycle
`timescale 1ns / 1ps

module segment_pair_closest_points (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [31:0] p0_x,
	input logic signed [31:0] p0_y,
	input logic signed [31:0] p0_z,
	input logic signed [31:0] p1_x,
	input logic signed [31:0] p1_y,
	input logic signed [31:0] p1_z,
	input logic signed [31:0] q0_x,
	input logic signed [31:0] q0_y,
	input logic signed [31:0] q0_z,
	input logic signed [31:0] q1_x,
	input logic signed [31:0] q1_y,
	input logic signed [31:0] q1_z,
	output logic done,
	output logic [16:0] param_first,
	output logic [16:0] param_second,
	output logic signed [31:0] near_first_x,
	output logic signed [31:0] near_first_y,
	output logic signed [31:0] near_first_z,
	output logic signed [31:0] near_second_x,
	output logic signed [31:0] near_second_y,
	output logic signed [31:0] near_second_z,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [spcp_pkg::PAW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import spcp_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic take, full, push, q_valid, done_c;
	seg_t seg;
	item_t f_item, q_item;
	res_t res;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready && paddr[PAW-1] == REG_THR) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[PAW-1] == REG_THR) ? {{(32-THR_W){1'b0}}, thr_q} : '0;

	// transaction accept
	assign busy = full;
	assign take = start && !full;

	assign seg.p0 = {p0_z, p0_y, p0_x};
	assign seg.p1 = {p1_z, p1_y, p1_x};
	assign seg.q0 = {q0_z, q0_y, q0_x};
	assign seg.q1 = {q1_z, q1_y, q1_x};

	spcp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.seg(seg),
		.thr(thr_q),
		.push(push),
		.item(f_item)
	);

	spcp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.full(full),
		.push(push),
		.wr_item(f_item),
		.rd_valid(q_valid),
		.rd_item(q_item)
	);

	spcp_solve u_solve (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(q_valid),
		.in_item(q_item),
		.thr(thr_q),
		.done(done_c),
		.res(res)
	);

	// result ports
	assign done = done_c;
	assign param_first = res.s1;
	assign param_second = res.s2;
	assign near_first_x = res.n1[0];
	assign near_first_y = res.n1[1];
	assign near_first_z = res.n1[2];
	assign near_second_x = res.n2[0];
	assign near_second_y = res.n2[1];
	assign near_second_z = res.n2[2];

endmodule

// ===== rtl/core/spcp_check.sv =====
// port level checks for segment_pair_closest_points, attached by bind
// depends on spcp_pkg
`timescale 1ns / 1ps

module spcp_check (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic signed [31:0] p0_x,
	input logic signed [31:0] p0_y,
	input logic signed [31:0] p0_z,
	input logic signed [31:0] p1_x,
	input logic signed [31:0] p1_y,
	input logic signed [31:0] p1_z,
	input logic signed [31:0] q0_x,
	input logic signed [31:0] q0_y,
	input logic signed [31:0] q0_z,
	input logic signed [31:0] q1_x,
	input logic signed [31:0] q1_y,
	input logic signed [31:0] q1_z,
	input logic done,
	input logic [16:0] param_first,
	input logic [16:0] param_second,
	input logic signed [31:0] near_first_x,
	input logic signed [31:0] near_first_y,
	input logic signed [31:0] near_first_z,
	input logic signed [31:0] near_second_x,
	input logic signed [31:0] near_second_y,
	input logic signed [31:0] near_second_z,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [spcp_pkg::PAW-1:0] paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic pready
);
	import spcp_pkg::*;

	// parameters never leave [0, one]
	a_param_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (param_first <= Q_ONE && param_second <= Q_ONE))
		else $error("parameter out of range");

	// no result right after reset release
	a_no_done_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !done)
		else $error("result strobe straight out of reset");

	// threshold readback shows the last written value
	a_thr_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[PAW-1] == REG_THR)
		|=> (paddr[PAW-1] != REG_THR || prdata[THR_W-1:0] == $past(pwdata[THR_W-1:0])))
		else $error("threshold readback mismatch");

	// bus never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind segment_pair_closest_points spcp_check u_check (.*);

// ===== tb/tb_top.sv =====
// testbench for segment_pair_closest_points: directed and random segment pairs, apb threshold
// writes, predicted results checked field by field; depends on rtl/core/spcp_pkg.sv and the rtl
`timescale 1ns / 1ps

module tb_top;
	import spcp_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [31:0] c[12];
	} pair_t;

	typedef struct {
		logic [16:0] s1;
		logic [16:0] s2;
		logic signed [31:0] n1[3];
		logic signed [31:0] n2[3];
	} near_t;

	localparam int LIMIT = 400000;
	localparam int DRAIN = 80;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [31:0] crd[12];
	logic done;
	logic [16:0] param_first, param_second;
	logic signed [31:0] near_first_x, near_first_y, near_first_z;
	logic signed [31:0] near_second_x, near_second_y, near_second_z;
	logic psel, penable, pwrite;
	logic [PAW-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	near_t expected_near[$];
	longint thr_model;
	int errors = 0;
	int cycles = 0;
	int burst_left = 1;

	segment_pair_closest_points uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.p0_x(crd[0]), .p0_y(crd[1]), .p0_z(crd[2]),
		.p1_x(crd[3]), .p1_y(crd[4]), .p1_z(crd[5]),
		.q0_x(crd[6]), .q0_y(crd[7]), .q0_z(crd[8]),
		.q1_x(crd[9]), .q1_y(crd[10]), .q1_z(crd[11]),
		.done(done), .param_first(param_first), .param_second(param_second),
		.near_first_x(near_first_x), .near_first_y(near_first_y),
		.near_first_z(near_first_z), .near_second_x(near_second_x),
		.near_second_y(near_second_y), .near_second_z(near_second_z),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// exact dot product rescaled to q16.16 by floor shift
	function automatic longint dot_q16(longint u[3], longint v[3]);
		wide_t acc;
		acc = wide_t'(u[0]) * wide_t'(v[0]) + wide_t'(u[1]) * wide_t'(v[1])
			+ wide_t'(u[2]) * wide_t'(v[2]);
		return longint'(acc >>> 16);
	endfunction

	// clamped quotient in q1.16, den positive
	function automatic longint clamp_ratio(wide_t num, wide_t den);
		if (num <= 0)
			return 0;
		if (num >= den)
			return 65536;
		return longint'((num <<< 16) / den);
	endfunction

	function automatic logic signed [31:0] near_coord(longint org, longint dir, longint s);
		longint x;
		x = org + ((dir * s) >>> 16);
		if (x > 64'sd2147483647)
			x = 64'sd2147483647;
		if (x < -64'sd2147483648)
			x = -64'sd2147483648;
		return x[31:0];
	endfunction

	// closest point solve for one pair at the current threshold
	function automatic near_t solve_closest(pair_t sp);
		longint p0[3], q0[3], d1[3], d2[3], r[3];
		longint a, e, b, c, f, s1, s2;
		wide_t den, t, top;
		near_t res;
		for (int i = 0; i < 3; i++) begin
			p0[i] = sp.c[i];
			q0[i] = sp.c[6+i];
			d1[i] = longint'(sp.c[3+i]) - p0[i];
			d2[i] = longint'(sp.c[9+i]) - q0[i];
			r[i] = p0[i] - q0[i];
		end
		a = dot_q16(d1, d1);
		e = dot_q16(d2, d2);
		f = dot_q16(d2, r);
		c = dot_q16(d1, r);
		b = dot_q16(d1, d2);
		s1 = 0;
		s2 = 0;
		if (a <= thr_model && e <= thr_model) begin
			s1 = 0;
		end else if (a <= thr_model) begin
			s2 = clamp_ratio(wide_t'(f), wide_t'(e));
		end else if (e <= thr_model) begin
			s1 = clamp_ratio(wide_t'(-c), wide_t'(a));
		end else begin
			den = wide_t'(a) * wide_t'(e) - wide_t'(b) * wide_t'(b);
			if (wide_t'(thr_model) < (den >>> 16))
				s1 = clamp_ratio(wide_t'(b) * wide_t'(f) - wide_t'(c) * wide_t'(e), den);
			t = wide_t'(b) * wide_t'(s1) + (wide_t'(f) <<< 16);
			top = wide_t'(e) <<< 16;
			if (t < 0) begin
				s2 = 0;
				s1 = clamp_ratio(wide_t'(-c), wide_t'(a));
			end else if (top < t) begin
				s2 = 65536;
				s1 = clamp_ratio(wide_t'(b - c), wide_t'(a));
			end else begin
				s2 = clamp_ratio(t, top);
			end
		end
		res.s1 = s1[16:0];
		res.s2 = s2[16:0];
		for (int i = 0; i < 3; i++) begin
			res.n1[i] = near_coord(p0[i], d1[i], s1);
			res.n2[i] = near_coord(q0[i], d2[i], s2);
		end
		return res;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		near_t w;
		if (done) begin
			if (expected_near.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				w = expected_near.pop_front();
				if (param_first !== w.s1) report("param_first", param_first, w.s1);
				if (param_second !== w.s2) report("param_second", param_second, w.s2);
				if (near_first_x !== w.n1[0]) report("near_first_x", near_first_x, w.n1[0]);
				if (near_first_y !== w.n1[1]) report("near_first_y", near_first_y, w.n1[1]);
				if (near_first_z !== w.n1[2]) report("near_first_z", near_first_z, w.n1[2]);
				if (near_second_x !== w.n2[0]) report("near_second_x", near_second_x, w.n2[0]);
				if (near_second_y !== w.n2[1]) report("near_second_y", near_second_y, w.n2[1]);
				if (near_second_z !== w.n2[2]) report("near_second_z", near_second_z, w.n2[2]);
			end
		end
	end

	// one transaction: hold start until an edge with busy low
	task automatic send_pair(pair_t sp);
		logic was_busy;
		for (int i = 0; i < 12; i++)
			crd[i] <= sp.c[i];
		start <= 1'b1;
		do begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
		end while (was_busy);
		expected_near.insert(expected_near.size(), solve_closest(sp));
	endtask

	task automatic go_idle(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// bursts of random length with random gaps
	task automatic send_paced(pair_t sp);
		send_pair(sp);
		burst_left--;
		if (burst_left <= 0) begin
			go_idle($urandom_range(1, 7));
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
	endtask

	task automatic drain;
		go_idle(1);
		while (expected_near.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_threshold(logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PAW'(4 * int'(REG_THR));
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		thr_model = longint'(v[15:0]);
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] q(int v);
		return 32'(v) <<< 16;
	endfunction

	function automatic pair_t make_pair(int v[12]);
		pair_t sp;
		for (int i = 0; i < 12; i++)
			sp.c[i] = q(v[i]);
		return sp;
	endfunction

	function automatic logic signed [31:0] rand_coord(int scale);
		case (scale)
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
			default: return $signed($urandom_range(0, 1023)) - 512;
		endcase
	endfunction

	// random pair, mostly with a shape that reaches the interesting branches
	function automatic pair_t rand_pair;
		pair_t sp;
		int scale;
		int shape;
		int k;
		scale = $urandom_range(0, 2);
		shape = $urandom_range(0, 5);
		for (int i = 0; i < 12; i++)
			sp.c[i] = rand_coord(scale);
		for (int i = 0; i < 3; i++) begin
			case (shape)
				1: sp.c[3+i] = sp.c[i] + rand_coord(2) / 64;
				2: sp.c[9+i] = sp.c[6+i] + rand_coord(2) / 64;
				3: begin
					sp.c[3+i] = sp.c[i] + rand_coord(2) / 64;
					sp.c[9+i] = sp.c[6+i] + rand_coord(2) / 64;
				end
				4: begin
					k = $urandom_range(0, 3);
					sp.c[9+i] = sp.c[6+i] + ((sp.c[3+i] - sp.c[i]) >>> k);
				end
				default: ;
			endcase
		end
		return sp;
	endfunction

	task automatic test_directed;
		pair_t sp;
		int v[12];
		// all zero and both segments points
		v = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_paced(make_pair(v));
		v = '{1, 2, 3, 1, 2, 3, 4, 5, 6, 4, 5, 6};
		send_paced(make_pair(v));
		// only the first segment a point
		v = '{5, 5, 0, 5, 5, 0, 0, 0, 0, 10, 0, 0};
		send_paced(make_pair(v));
		// only the second segment a point
		v = '{0, 0, 0, 10, 0, 0, -3, 4, 1, -3, 4, 1};
		send_paced(make_pair(v));
		// parallel segments
		v = '{0, 0, 0, 10, 0, 0, 2, 3, 0, 12, 3, 0};
		send_paced(make_pair(v));
		v = '{0, 0, 0, 10, 0, 0, 12, 3, 0, 2, 3, 0};
		send_paced(make_pair(v));
		// crossing in the interior
		v = '{0, 0, 0, 10, 0, 0, 5, -5, 2, 5, 5, 2};
		send_paced(make_pair(v));
		// re-clamp with the second parameter below zero and above one
		v = '{0, 0, 0, 10, 0, 0, 15, 2, 0, 20, 8, 0};
		send_paced(make_pair(v));
		v = '{0, 0, 0, 10, 0, 0, 20, 8, 0, 15, 2, 0};
		send_paced(make_pair(v));
		v = '{0, 0, 0, 10, 1, 0, -6, -1, 0, -2, 9, 3};
		send_paced(make_pair(v));
		// coordinate extremes and saturation
		for (int i = 0; i < 12; i++)
			sp.c[i] = (i % 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
		send_paced(sp);
		for (int i = 0; i < 12; i++)
			sp.c[i] = (i < 6) ? 32'sh7fff_ffff : 32'sh8000_0000;
		send_paced(sp);
		for (int i = 0; i < 12; i++)
			sp.c[i] = (i / 3 == 1 || i / 3 == 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
		send_paced(sp);
		for (int i = 0; i < 12; i++)
			sp.c[i] = 32'sh8000_0000;
		send_paced(sp);
		for (int i = 0; i < 12; i++)
			sp.c[i] = 32'sh7fff_ffff;
		send_paced(sp);
		// tiny lengths near the threshold
		for (int i = 0; i < 12; i++)
			sp.c[i] = 0;
		sp.c[3] = 32'sd256;
		sp.c[9] = 32'sd257;
		sp.c[7] = 32'sd100;
		send_paced(sp);
		drain();
	endtask

	task automatic test_threshold_extremes;
		write_threshold(32'h0000_0000);
		test_directed();
		write_threshold(32'hffff_ffff);
		test_directed();
	endtask

	task automatic test_random;
		logic [31:0] thr_pick[4];
		thr_pick = '{32'h0000_0001, 32'h0000_0000, 32'h0000_ffff, 32'h0000_0000};
		for (int ph = 0; ph < 5; ph++) begin
			if (ph < 4)
				write_threshold(thr_pick[ph]);
			else
				write_threshold($urandom);
			for (int n = 0; n < 200; n++)
				send_paced(rand_pair());
			drain();
		end
	endtask

	initial begin
		thr_model = 1;
		arst_n <= 1'b0;
		start <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		for (int i = 0; i < 12; i++)
			crd[i] <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_threshold_extremes();
		test_random();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
